[design/btnar_pkg.sv]
package btnar_pkg;

  localparam int unsigned BtnW     = 16;
  localparam int unsigned LeftBit  = 0;
  localparam int unsigned RightBit = 1;
  localparam int unsigned CfgW     = 8;
  localparam int unsigned CntW     = CfgW + 1;

  localparam logic [BtnW-1:0] LeftMask  = BtnW'(1) << LeftBit;
  localparam logic [BtnW-1:0] RightMask = BtnW'(1) << RightBit;
  localparam logic [BtnW-1:0] DirMask   = LeftMask | RightMask;
  localparam logic [BtnW-1:0] RightOnly = RightMask & ~LeftMask;

  typedef enum logic [0:0] {
    CFG_SHIFT_DELAY   = 1'b0,
    CFG_REPEAT_PERIOD = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2
  } dir_e;

  typedef struct packed {
    logic [CfgW-1:0] shift_delay;
    logic [CfgW-1:0] repeat_period;
  } cfg_t;

endpackage

[design/btnar_cfg.sv]
module btnar_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  btnar_pkg::cfg_idx_e      cfg_index_i,
  input  logic [btnar_pkg::CfgW-1:0] cfg_data_i,
  output btnar_pkg::cfg_t          cfg_o
);
  import btnar_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SHIFT_DELAY:   cfg_d.shift_delay   = cfg_data_i;
        CFG_REPEAT_PERIOD: cfg_d.repeat_period = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shift_delay   <= CfgW'(10);
      cfg_q.repeat_period <= CfgW'(2);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[design/btnar_step.sv]
module btnar_step (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  btnar_pkg::cfg_t            cfg_i,
  input  logic                       step_i,
  input  logic [btnar_pkg::BtnW-1:0] held_i,
  output logic [btnar_pkg::BtnW-1:0] eff_o
);
  import btnar_pkg::*;

  logic [BtnW-1:0]   prev_q;
  dir_e              dir_q, dir_d;
  logic signed [CntW-1:0] cnt_q, cnt_d, cnt_dec, delay_s, period_s;
  logic [BtnW-1:0]   eff0, dm, eff;

  assign delay_s  = signed'({1'b0, cfg_i.shift_delay});
  assign period_s = signed'({1'b0, cfg_i.repeat_period});
  assign cnt_dec  = cnt_q - CntW'(1);
  assign eff0     = (held_i & ~DirMask) | (held_i & ~prev_q);

  always_comb begin
    case (dir_q)
      DIR_LEFT:  dm = LeftMask;
      DIR_RIGHT: dm = RightMask;
      default:   dm = '0;
    endcase
  end

  always_comb begin
    eff   = eff0;
    dir_d = dir_q;
    cnt_d = cnt_q;
    if (|(eff0 & DirMask)) begin
      cnt_d = delay_s;
      if (|(eff0 & LeftMask)) begin
        dir_d = DIR_LEFT;
        eff   = eff0 & ~RightOnly;
      end else begin
        dir_d = DIR_RIGHT;
      end
    end else if (|(held_i & dm)) begin
      cnt_d = cnt_dec;
      if (cnt_dec <= 0) begin
        eff   = eff0 | dm;
        cnt_d = period_s;
      end
    end else begin
      cnt_d = delay_s;
      if (|(held_i & LeftMask)) begin
        dir_d = DIR_LEFT;
        eff   = eff0 | LeftMask;
      end else if (|(held_i & RightMask)) begin
        dir_d = DIR_RIGHT;
        eff   = eff0 | RightMask;
      end else begin
        dir_d = DIR_NONE;
      end
    end
  end

  assign eff_o = eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      dir_q  <= DIR_NONE;
      cnt_q  <= '0;
    end else if (step_i) begin
      prev_q <= held_i;
      dir_q  <= dir_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[design/button_autorepeat_filter_core.sv]
// Each item passes the input register, then the result register.
// Throughput: one item per cycle; while a result waits on stall the input
//   register takes one more item, and then the input stalls.
// Reset: asynchronous, active low; clears the pipeline, direction tracking,
//   previous buttons and countdown, and loads delay 10 and period 2.
module button_autorepeat_filter_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [btnar_pkg::BtnW-1:0] buttons_held_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [btnar_pkg::BtnW-1:0] buttons_effective_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  btnar_pkg::cfg_idx_e        cfg_index_i,
  input  logic [btnar_pkg::CfgW-1:0] cfg_data_i
);
  import btnar_pkg::*;

  cfg_t            cfg;
  logic            in_valid_q, in_valid_d;
  logic [BtnW-1:0] held_q;
  logic            out_valid_q, out_valid_d;
  logic [BtnW-1:0] eff_q, eff;
  logic            out_free, advance, in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  btnar_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  btnar_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .held_i (held_q),
    .eff_o  (eff)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      held_q <= buttons_held_i;
    end
    if (advance) begin
      eff_q <= eff;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign buttons_effective_o = eff_q;

  a_advance_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("advanced item did not reach result register");

  a_one_direction : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (LeftBit != RightBit) |->
      !(buttons_effective_o[LeftBit] && buttons_effective_o[RightBit]))
    else $error("left and right both output");

  a_stall_has_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with nothing pending");

endmodule

[sim/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btnar_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int NumPhases  = 6;

  logic            clk_i;
  logic            rst_ni         = 1'b0;
  logic            in_valid_i     = 1'b0;
  logic            in_stall_o;
  logic [BtnW-1:0] buttons_held_i = '0;
  logic            out_valid_o;
  logic            out_stall_i    = 1'b0;
  logic [BtnW-1:0] buttons_effective_o;
  logic            cfg_valid_i    = 1'b0;
  logic            cfg_ready_o;
  cfg_idx_e        cfg_index_i    = CFG_SHIFT_DELAY;
  logic [CfgW-1:0] cfg_data_i     = '0;

  button_autorepeat_filter_core uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .buttons_held_i     (buttons_held_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .buttons_effective_o(buttons_effective_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // predictor state
  logic [CfgW-1:0]        shift_delay_m  = 8'd10;
  logic [CfgW-1:0]        repeat_period_m = 8'd2;
  logic [BtnW-1:0]        prev_held_m    = '0;
  dir_e                   tracked_dir_m  = DIR_NONE;
  logic signed [CntW-1:0] countdown_m    = '0;

  logic [BtnW-1:0] held_words_q[$];
  logic [BtnW-1:0] effective_q[$];

  logic item_taken = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   long_hold_req = 1'b0;
  int   hold_left = 0;
  int   errors = 0;
  int   cycle_cnt = 0;

  logic [CfgW-1:0] phase_delay  [NumPhases] = '{8'd0, 8'd1, 8'd3, 8'd255, 8'd6, 8'd0};
  logic [CfgW-1:0] phase_period [NumPhases] = '{8'd0, 8'd1, 8'd5, 8'd255, 8'd2, 8'd255};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [BtnW-1:0] dir_bits(input dir_e d);
    return (d == DIR_LEFT) ? LeftMask : (d == DIR_RIGHT) ? RightMask : '0;
  endfunction

  function automatic logic [BtnW-1:0] filter_tick(input logic [BtnW-1:0] held);
    logic [BtnW-1:0] eff;
    logic [BtnW-1:0] trk;
    eff = (held & ~DirMask) | (held & ~prev_held_m);
    prev_held_m = held;
    if ((eff & DirMask) != '0) begin
      countdown_m = {1'b0, shift_delay_m};
      if ((eff & LeftMask) != '0) begin
        tracked_dir_m = DIR_LEFT;
        eff = eff & ~RightOnly;
      end else begin
        tracked_dir_m = DIR_RIGHT;
      end
    end else begin
      trk = dir_bits(tracked_dir_m);
      if ((held & trk) != '0) begin
        countdown_m = countdown_m - CntW'(1);
        if (countdown_m <= 0) begin
          eff = eff | trk;
          countdown_m = {1'b0, repeat_period_m};
        end
      end else begin
        if ((held & LeftMask) != '0) tracked_dir_m = DIR_LEFT;
        else if ((held & RightMask) != '0) tracked_dir_m = DIR_RIGHT;
        else tracked_dir_m = DIR_NONE;
        countdown_m = {1'b0, shift_delay_m};
        eff = eff | dir_bits(tracked_dir_m);
      end
    end
    return eff;
  endfunction

  // sample both channels
  always @(posedge clk_i) begin
    logic [BtnW-1:0] exp_word;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        item_taken = 1'b1;
        effective_q.push_back(filter_tick(buttons_held_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (effective_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item: got %h", buttons_effective_o);
        end else begin
          exp_word = effective_q.pop_front();
          if (buttons_effective_o !== exp_word) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: expected %h got %h", exp_word, buttons_effective_o);
            end
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || item_taken) begin
      if (held_words_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i     <= 1'b1;
        buttons_held_i <= held_words_q.pop_front();
      end else begin
        in_valid_i     <= 1'b0;
        buttons_held_i <= BtnW'($urandom);
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 200;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (held_words_q.size() != 0 || in_valid_i || effective_q.size() != 0);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SHIFT_DELAY) shift_delay_m = val;
    else repeat_period_m = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= CfgW'($urandom);
    #1;
  endtask

  task automatic queue_random(input int n, input int run_cap);
    int              left;
    int              run;
    int              i;
    logic [1:0]      dirs;
    logic [BtnW-1:0] w;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        held_words_q.push_back(BtnW'($urandom));
        left--;
      end else begin
        dirs = 2'($urandom);
        run  = $urandom_range(1, run_cap);
        for (i = 0; i < run && left > 0; i++) begin
          w = (BtnW'($urandom) & ~DirMask) | (dirs[0] ? LeftMask : '0) |
              (dirs[1] ? RightMask : '0);
          held_words_q.push_back(w);
          left--;
        end
      end
    end
  endtask

  initial begin
    int ph;
    int cap;
    int i;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    #1;

    held_words_q.push_back(16'h0000);
    held_words_q.push_back(16'h0001);
    for (i = 0; i < 10; i++) held_words_q.push_back(16'h0001);
    held_words_q.push_back(16'h0003);
    held_words_q.push_back(16'h0001);
    held_words_q.push_back(16'h0003);
    held_words_q.push_back(16'h0002);
    held_words_q.push_back(16'hFFFC);
    held_words_q.push_back(16'hFFFF);
    held_words_q.push_back(16'hFFFE);
    held_words_q.push_back(16'hFFFE);
    held_words_q.push_back(16'h8000);
    held_words_q.push_back(16'h0000);
    wait_idle();

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      write_cfg(CFG_SHIFT_DELAY, phase_delay[ph]);
      write_cfg(CFG_REPEAT_PERIOD, phase_period[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 57;
        end
        default: begin
          send_idle_pct = 13;
          stall_pct = 13;
        end
      endcase
      cap = phase_delay[ph] + 2 * phase_period[ph] + 3;
      if (cap > 40) cap = 40;
      if (ph == 0) long_hold_req = 1'b1;
      queue_random(22, cap);
      if (ph == 3) begin
        for (i = 0; i < 260; i++) begin
          held_words_q.push_back((BtnW'($urandom) & ~DirMask) | LeftMask);
        end
      end
      wait_idle();
      queue_random(22, cap);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && effective_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
